// File: rtl/core/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce and press classifier package
// Shared widths, reset values, register indexes and the structs that travel
// between the configuration block, the classifier and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

    // Default width of the internal time arithmetic.
    localparam int unsigned TIME_WIDTH_DEF = 32;

    // Fixed widths of the ports.
    localparam int unsigned CFG_WIDTH     = 32;
    localparam int unsigned CFG_IDX_WIDTH = 2;
    localparam int unsigned STAMP_WIDTH   = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_LIMIT  = 2'd2;

    // Reset values of the configuration registers, in microseconds.
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST    = 32'd50000;
    localparam logic [CFG_WIDTH-1:0] SHORT_LIMIT_RST = 32'd500000;
    localparam logic [CFG_WIDTH-1:0] LONG_LIMIT_RST  = 32'd1000000;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_us;
        logic [CFG_WIDTH-1:0] short_limit_us;
        logic [CFG_WIDTH-1:0] long_limit_us;
    } cfg_t;

    typedef struct packed {
        logic pressing;
        logic steady_level;
        logic press_edge;
        logic release_edge;
        logic short_press_event;
        logic long_press_event;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/bdpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the debounce time and the short and long press limits. Writes to an
// index beyond the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_cfg_regs
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [bdpc_pkg::CFG_IDX_WIDTH-1:0]   wr_index,
    input  wire logic [bdpc_pkg::CFG_WIDTH-1:0]       wr_data,
    output bdpc_pkg::cfg_t                            cfg
);

    bdpc_pkg::cfg_t cfg_reg;
    bdpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bdpc_pkg::REG_DEBOUNCE:    cfg_next.debounce_us    = wr_data;
                bdpc_pkg::REG_SHORT_LIMIT: cfg_next.short_limit_us = wr_data;
                bdpc_pkg::REG_LONG_LIMIT:  cfg_next.long_limit_us  = wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_us    <= bdpc_pkg::DEBOUNCE_RST;
            cfg_reg.short_limit_us <= bdpc_pkg::SHORT_LIMIT_RST;
            cfg_reg.long_limit_us  <= bdpc_pkg::LONG_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/bdpc_classify.sv
// ----------------------------------------------------------------------------
// Debounce and press classifier core
// Holds the debounce and press state and computes one scan's result. The
// state advances only on a cycle where step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_classify
#(
    parameter int unsigned TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   raw,
    input  wire logic [TIME_WIDTH-1:0]  now,
    input  bdpc_pkg::cfg_t              cfg,
    output bdpc_pkg::result_t           res
);

    logic                  last_raw_reg,     last_raw_next;
    logic [TIME_WIDTH-1:0] change_stamp_reg, change_stamp_next;
    logic                  cur_steady_reg,   cur_steady_next;
    logic                  held_reg,         held_next;
    logic                  long_done_reg,    long_done_next;
    logic [TIME_WIDTH-1:0] press_stamp_reg,  press_stamp_next;

    logic [TIME_WIDTH-1:0] debounce_lim;
    logic [TIME_WIDTH-1:0] short_lim;
    logic [TIME_WIDTH-1:0] long_lim;
    logic [TIME_WIDTH-1:0] settle_diff;
    logic [TIME_WIDTH-1:0] hold_diff;
    logic                  raw_changed;
    logic                  settled;
    logic                  press_edge;
    logic                  release_edge;
    logic                  short_ev;
    logic                  long_ev;

    // Limits taken at the width of the time arithmetic.
    assign debounce_lim = TIME_WIDTH'(cfg.debounce_us);
    assign short_lim    = TIME_WIDTH'(cfg.short_limit_us);
    assign long_lim     = TIME_WIDTH'(cfg.long_limit_us);

    always_comb
    begin
        raw_changed       = (raw != last_raw_reg);
        last_raw_next     = raw;
        change_stamp_next = raw_changed ? now : change_stamp_reg;

        // A raw change restarts the timer, so the difference is then zero.
        settle_diff = now - change_stamp_next;
        settled     = (settle_diff >= debounce_lim);

        press_edge   = settled &&  cur_steady_reg && !raw;
        release_edge = settled && !cur_steady_reg &&  raw;

        cur_steady_next = settled ? raw  : cur_steady_reg;
        held_next       = settled ? !raw : held_reg;

        // Hold time against the stored press stamp. A press edge never coincides
        // with a release edge and long_ev excludes it, so neither event can fire on that scan.
        hold_diff = now - press_stamp_reg;
        short_ev  = release_edge && (hold_diff < short_lim);
        long_ev   = held_next && !long_done_reg && !press_edge && (hold_diff > long_lim);

        press_stamp_next = press_edge ? now : press_stamp_reg;
        if (press_edge)
        begin
            long_done_next = 1'b0;
        end
        else
        begin
            long_done_next = long_done_reg || long_ev;
        end

        res.pressing          = held_next;
        res.steady_level      = cur_steady_next;
        res.press_edge        = press_edge;
        res.release_edge      = release_edge;
        res.short_press_event = short_ev;
        res.long_press_event  = long_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b1;
            change_stamp_reg <= '0;
            cur_steady_reg   <= 1'b1;
            held_reg         <= 1'b0;
            long_done_reg    <= 1'b0;
            press_stamp_reg  <= '0;
        end
        else if (step)
        begin
            last_raw_reg     <= last_raw_next;
            change_stamp_reg <= change_stamp_next;
            cur_steady_reg   <= cur_steady_next;
            held_reg         <= held_next;
            long_done_reg    <= long_done_next;
            press_stamp_reg  <= press_stamp_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/button_debounce_press_classifier.sv
// A scan beat passes the input register and then the result register before its result is out.
// One scan per cycle while results are not stalled; the classifier state updates once per scan in one pass.
// The result register accepts a new beat whenever it is empty or its beat is taken that cycle.
// Reset (rst_n low, asynchronous) empties both registers, restores the register defaults and
// returns the button state to released, not pressing, with all time stamps at zero.
// ----------------------------------------------------------------------------
// Button debounce and press classifier
// Debounces an active-low button sampled with a microsecond timestamp and
// reports the steady level, the pressing state, press and release edges, and
// short and long press events, one result beat per scan beat.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier
#(
    parameter int unsigned TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Scan input channel.
    input  wire logic                                 in_valid,
    output wire logic                                 in_stall,
    input  wire logic                                 raw_level,
    input  wire logic [bdpc_pkg::STAMP_WIDTH-1:0]     now_us,

    // Result channel.
    output wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    output wire logic                                 pressing,
    output wire logic                                 steady_level,
    output wire logic                                 press_edge,
    output wire logic                                 release_edge,
    output wire logic                                 short_press_event,
    output wire logic                                 long_press_event,

    // Configuration write channel.
    input  wire logic                                 cfg_valid,
    output wire logic                                 cfg_ready,
    input  wire logic [bdpc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  wire logic [bdpc_pkg::CFG_WIDTH-1:0]       cfg_data
);

    bdpc_pkg::cfg_t    cfg;
    bdpc_pkg::result_t res;
    bdpc_pkg::result_t res_reg;

    logic                  in_valid_reg, in_valid_next;
    logic                  raw_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  in_accept;
    logic                  res_load;
    logic                  step;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    bdpc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register takes a beat when it is empty or being drained.
    // The input register only pushes back when it holds a beat that cannot
    // move on, so a new scan is taken every cycle as long as results flow.
    assign res_load  = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !res_load;
    assign in_accept = in_valid && !in_stall;
    assign step      = in_valid_reg && res_load;

    assign in_valid_next  = in_accept || (in_valid_reg && !res_load);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload. The timestamp is brought to the width of the
    // time arithmetic here: truncated when narrower, zero extended when wider.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            raw_reg <= raw_level;
            now_reg <= TIME_WIDTH'(now_us);
        end
    end

    bdpc_classify
    #(
        .TIME_WIDTH (TIME_WIDTH)
    )
    u_classify
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .raw   (raw_reg),
        .now   (now_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pressing          = res_reg.pressing;
    assign steady_level      = res_reg.steady_level;
    assign press_edge        = res_reg.press_edge;
    assign release_edge      = res_reg.release_edge;
    assign short_press_event = res_reg.short_press_event;
    assign long_press_event  = res_reg.long_press_event;

    // The pressing flag always mirrors the steady level.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pressing == !steady_level))
        else $error("pressing does not mirror the steady level");

    // A short press is only ever reported together with a release edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && short_press_event) |-> release_edge)
        else $error("short press reported without a release edge");

    // A press edge leaves the button held, and never fires a long press.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && press_edge) |-> (pressing && !release_edge && !long_press_event))
        else $error("inconsistent press edge result");

    // The input side only stalls while a result beat is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

endmodule

`default_nettype wire
